@@ hw/rtl/keyframe_pose_player_defines.svh @@
// Assertion macros for the keyframe pose player.
// Used by the top level only; no other dependencies.
`ifndef KEYFRAME_POSE_PLAYER_DEFINES_SVH
`define KEYFRAME_POSE_PLAYER_DEFINES_SVH
`ifndef SYNTHESIS
`define KPP_ASSERT_NEVER(lbl, cond) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) \
        else $error("kpp: forbidden condition");
`define KPP_ASSERT_NEXT(lbl, pre, post) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (pre) |=> (post)) \
        else $error("kpp: sequence violated");
`else
`define KPP_ASSERT_NEVER(lbl, cond)
`define KPP_ASSERT_NEXT(lbl, pre, post)
`endif
`endif

@@ hw/rtl/kpp_pkg.sv @@
// Package for the keyframe pose player: codes, keyframe ROM, command/status types.
// No dependencies.
`timescale 1ns / 1ps
package kpp_pkg;

    localparam int KEYFRAME_ROM_DEPTH_DEF = 32;
    localparam int MAX_SEGMENTS_DEF       = 9;
    localparam int ANG_W                  = 15;
    localparam int DT_W                   = 21;
    localparam int DUR_W                  = 20;
    localparam int FRAC_W                 = 17;
    localparam int NUM_W                  = DT_W + 16;
    localparam int IDX_W                  = 6;

    localparam logic [1:0] CMD_TICK   = 2'd0;
    localparam logic [1:0] CMD_START  = 2'd1;
    localparam logic [1:0] CMD_CANCEL = 2'd2;

    localparam logic [2:0] TRICK_WAVE  = 3'd0;
    localparam logic [2:0] TRICK_BOW   = 3'd1;
    localparam logic [2:0] TRICK_BEG   = 3'd2;
    localparam logic [2:0] TRICK_SHAKE = 3'd3;
    localparam logic [2:0] TRICK_NONE  = 3'd4;

    localparam logic [FRAC_W-1:0] FRAC_ONE  = 17'd65536;
    localparam logic [FRAC_W-1:0] FRAC_HALF = 17'd32768;

    typedef logic [11:0][ANG_W-1:0] pose_t;

    typedef struct packed {
        pose_t            ang;
        logic [DUR_W-1:0] dur;
    } frame_t;

    typedef struct packed {
        logic             load;
        logic             advance;
        logic             div_init;
        logic             div_step;
        logic             mul_step;
        logic [IDX_W-1:0] idx;
    } kpp_cmd_t;

    typedef struct packed {
        logic adv_more;
    } kpp_status_t;

    function automatic logic [3*ANG_W-1:0] leg3(input int a, input int b, input int c);
        logic [ANG_W-1:0] ea;
        logic [ANG_W-1:0] eb;
        logic [ANG_W-1:0] ec;
        ea = ANG_W'(a);
        eb = ANG_W'(b);
        ec = ANG_W'(c);
        return {ec, eb, ea};
    endfunction

    localparam logic [3*ANG_W-1:0] STAND   = leg3(0, 3129, -6742);
    localparam logic [3*ANG_W-1:0] W_UP    = leg3(492, 1311, -9011);
    localparam logic [3*ANG_W-1:0] W_LEFT  = leg3(-819, 1147, -9011);
    localparam logic [3*ANG_W-1:0] W_RIGHT = leg3(1843, 1556, -9011);
    localparam logic [3*ANG_W-1:0] B_FRONT = leg3(0, 4588, -8602);
    localparam logic [3*ANG_W-1:0] B_REAR  = leg3(0, 3195, -6554);
    localparam logic [3*ANG_W-1:0] G_FRONT = leg3(737, 5939, -8397);
    localparam logic [3*ANG_W-1:0] G_REAR  = leg3(0, 5530, -10445);
    localparam logic [3*ANG_W-1:0] S_POS   = leg3(901, 3129, -6742);
    localparam logic [3*ANG_W-1:0] S_NEG   = leg3(-655, 3129, -6742);

    localparam pose_t STAND_POSE = {STAND, STAND, STAND, STAND};

    function automatic frame_t rom_frame(input logic [4:0] idx);
        frame_t f;
        f = '0;
        unique case (idx)
            5'd0:  f = '{{STAND, STAND, STAND, W_UP}, 20'd450000};
            5'd1:  f = '{{STAND, STAND, STAND, W_LEFT}, 20'd220000};
            5'd2:  f = '{{STAND, STAND, STAND, W_RIGHT}, 20'd220000};
            5'd3:  f = '{{STAND, STAND, STAND, W_LEFT}, 20'd220000};
            5'd4:  f = '{{STAND, STAND, STAND, W_RIGHT}, 20'd220000};
            5'd5:  f = '{{STAND, STAND, STAND, W_UP}, 20'd200000};
            5'd6:  f = '{STAND_POSE, 20'd450000};
            5'd7:  f = '{{B_REAR, B_REAR, B_FRONT, B_FRONT}, 20'd600000};
            5'd8:  f = '{{B_REAR, B_REAR, B_FRONT, B_FRONT}, 20'd700000};
            5'd9:  f = '{STAND_POSE, 20'd600000};
            5'd10: f = '{{G_REAR, G_REAR, G_FRONT, G_FRONT}, 20'd650000};
            5'd11: f = '{{G_REAR, G_REAR, G_FRONT, G_FRONT}, 20'd900000};
            5'd12: f = '{STAND_POSE, 20'd650000};
            5'd13: f = '{{S_NEG, S_POS, S_NEG, S_POS}, 20'd180000};
            5'd14: f = '{{S_POS, S_NEG, S_POS, S_NEG}, 20'd140000};
            5'd15: f = '{{S_NEG, S_POS, S_NEG, S_POS}, 20'd140000};
            5'd16: f = '{{S_POS, S_NEG, S_POS, S_NEG}, 20'd140000};
            5'd17: f = '{{S_NEG, S_POS, S_NEG, S_POS}, 20'd140000};
            5'd18: f = '{{S_POS, S_NEG, S_POS, S_NEG}, 20'd140000};
            5'd19: f = '{{S_NEG, S_POS, S_NEG, S_POS}, 20'd140000};
            5'd20: f = '{{S_POS, S_NEG, S_POS, S_NEG}, 20'd140000};
            5'd21: f = '{STAND_POSE, 20'd350000};
            default: f = '0;
        endcase
        return f;
    endfunction

    function automatic logic [3:0] trick_base(input logic [2:0] trk);
        logic [3:0] b;
        b = 4'd0;
        unique case (trk)
            TRICK_WAVE:  b = 4'd0;
            TRICK_BOW:   b = 4'd7;
            TRICK_BEG:   b = 4'd10;
            TRICK_SHAKE: b = 4'd13;
            default:     b = 4'd0;
        endcase
        return b;
    endfunction

    function automatic logic [3:0] trick_len(input logic [2:0] trk);
        logic [3:0] n;
        n = 4'd0;
        unique case (trk)
            TRICK_WAVE:  n = 4'd7;
            TRICK_BOW:   n = 4'd3;
            TRICK_BEG:   n = 4'd3;
            TRICK_SHAKE: n = 4'd9;
            default:     n = 4'd0;
        endcase
        return n;
    endfunction

endpackage

@@ hw/rtl/kpp_ctrl.sv @@
// Sequencer for the keyframe pose player: command, segment advance, divide,
// blend and output phases. Depends on kpp_pkg.
`timescale 1ns / 1ps
module kpp_ctrl (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    output logic               in_ready,
    output logic               out_valid,
    input  logic               out_ready,
    output logic               out_last,
    input  kpp_pkg::kpp_status_t status,
    output kpp_pkg::kpp_cmd_t    cmd
);
    import kpp_pkg::*;

    localparam logic [2:0] ST_IDLE = 3'd0;
    localparam logic [2:0] ST_ADV  = 3'd1;
    localparam logic [2:0] ST_DIV  = 3'd2;
    localparam logic [2:0] ST_MUL  = 3'd3;
    localparam logic [2:0] ST_OUT  = 3'd4;

    localparam logic [IDX_W-1:0] DIV_TOP  = IDX_W'(NUM_W - 1);
    localparam logic [IDX_W-1:0] MUL_LAST = IDX_W'(11);
    localparam logic [IDX_W-1:0] LEG_LAST = IDX_W'(3);

    logic [2:0]       state_reg;
    logic [2:0]       state_next;
    logic [IDX_W-1:0] cnt_reg;
    logic [IDX_W-1:0] cnt_next;

    assign in_ready  = (state_reg == ST_IDLE);
    assign out_valid = (state_reg == ST_OUT);
    assign out_last  = out_valid && (cnt_reg == LEG_LAST);

    always_comb
    begin
        state_next   = state_reg;
        cnt_next     = cnt_reg;
        cmd          = '0;
        cmd.idx      = cnt_reg;
        cmd.load     = in_valid && in_ready;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (in_valid)
                begin
                    state_next = ST_ADV;
                end
            end
            ST_ADV:
            begin
                if (status.adv_more)
                begin
                    cmd.advance = 1'b1;
                end
                else
                begin
                    cmd.div_init = 1'b1;
                    cnt_next     = DIV_TOP;
                    state_next   = ST_DIV;
                end
            end
            ST_DIV:
            begin
                cmd.div_step = 1'b1;
                if (cnt_reg == '0)
                begin
                    state_next = ST_MUL;
                end
                else
                begin
                    cnt_next = cnt_reg - 1'b1;
                end
            end
            ST_MUL:
            begin
                cmd.mul_step = 1'b1;
                if (cnt_reg == MUL_LAST)
                begin
                    cnt_next   = '0;
                    state_next = ST_OUT;
                end
                else
                begin
                    cnt_next = cnt_reg + 1'b1;
                end
            end
            ST_OUT:
            begin
                if (out_ready)
                begin
                    if (cnt_reg == LEG_LAST)
                    begin
                        cnt_next   = '0;
                        state_next = ST_IDLE;
                    end
                    else
                    begin
                        cnt_next = cnt_reg + 1'b1;
                    end
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            cnt_reg   <= '0;
        end
        else
        begin
            state_reg <= state_next;
            cnt_reg   <= cnt_next;
        end
    end

endmodule

@@ hw/rtl/kpp_datapath.sv @@
// Datapath for the keyframe pose player: player state, keyframe lookup,
// bit-serial divider, shared blend multiplier and result mux. Depends on kpp_pkg.
`timescale 1ns / 1ps
module kpp_datapath #(
    parameter int KEYFRAME_ROM_DEPTH = kpp_pkg::KEYFRAME_ROM_DEPTH_DEF,
    parameter int MAX_SEGMENTS       = kpp_pkg::MAX_SEGMENTS_DEF
) (
    input  logic                       clk,
    input  logic                       rst_n,
    input  kpp_pkg::kpp_cmd_t          cmd,
    output kpp_pkg::kpp_status_t       status,
    input  logic [1:0]                 in_command,
    input  logic [2:0]                 in_trick,
    input  logic [kpp_pkg::DT_W-1:0]   in_dt,
    output logic [1:0]                 leg,
    output logic [kpp_pkg::ANG_W-1:0]  roll_ang,
    output logic [kpp_pkg::ANG_W-1:0]  pitch_ang,
    output logic [kpp_pkg::ANG_W-1:0]  knee,
    output logic [kpp_pkg::FRAC_W-1:0] blend_weight,
    output logic                       playing,
    output logic [2:0]                 current_trick,
    output logic                       accepted
);
    import kpp_pkg::*;

    logic             running_reg;
    logic [2:0]       trick_reg;
    logic [3:0]       segment_reg;
    logic [DT_W-1:0]  elapsed_reg;
    pose_t            start_pose_reg;
    logic             accepted_reg;
    logic [DUR_W-1:0] rem_reg;
    logic [NUM_W-1:0] quo_reg;
    pose_t            pose_reg;

    logic              trick_ok;
    logic [3:0]        seg_n;
    logic [4:0]        rom_idx;
    frame_t            frame;
    logic [DUR_W-1:0]  dur;
    logic [DT_W-1:0]   dt_pos;
    logic              active;
    logic [NUM_W-1:0]  num;
    logic [DUR_W:0]    trial;
    logic              ge;
    logic [FRAC_W-1:0] t;
    logic [3:0]        j;
    logic signed [15:0] diff;
    logic signed [33:0] prod;
    logic [33:0]       mag;
    logic [33:0]       rnd;
    logic [16:0]       r;
    logic [16:0]       a_ext;
    logic [16:0]       blended;
    logic [3:0]        pbase;
    logic [17:0]       tri_down;

    assign trick_ok = (trick_reg <= TRICK_SHAKE);
    assign seg_n    = !trick_ok ? 4'd0 :
                      (int'(trick_len(trick_reg)) < MAX_SEGMENTS) ? trick_len(trick_reg) :
                      4'(MAX_SEGMENTS);
    assign rom_idx  = {1'b0, trick_base(trick_reg)} + {1'b0, segment_reg};
    assign frame    = (trick_ok && (int'(rom_idx) < KEYFRAME_ROM_DEPTH)) ?
                      rom_frame(rom_idx) : '0;
    assign dur      = (frame.dur == '0) ? DUR_W'(1) : frame.dur;
    assign dt_pos   = in_dt[DT_W-1] ? '0 : in_dt;
    assign active   = running_reg && (segment_reg < seg_n);

    assign status.adv_more = active && (elapsed_reg >= {1'b0, dur});

    // bit-serial restoring divide of elapsed * 2^16 by the segment duration
    assign num   = {elapsed_reg, 16'd0};
    assign trial = {rem_reg, num[cmd.idx]};
    assign ge    = (trial >= {1'b0, dur});

    always_comb
    begin
        if (!active)
        begin
            t = '0;
        end
        else if ((quo_reg[NUM_W-1:FRAC_W] != '0) || (quo_reg[FRAC_W-1:0] > FRAC_ONE))
        begin
            t = FRAC_ONE;
        end
        else
        begin
            t = quo_reg[FRAC_W-1:0];
        end
    end

    assign j       = cmd.idx[3:0];
    assign diff    = $signed({frame.ang[j][ANG_W-1], frame.ang[j]})
                   - $signed({start_pose_reg[j][ANG_W-1], start_pose_reg[j]});
    assign prod    = $signed({1'b0, t}) * diff;
    assign mag     = prod[33] ? 34'(-prod) : prod;
    assign rnd     = mag + 34'd32768;
    assign r       = rnd[32:16];
    assign a_ext   = {{2{start_pose_reg[j][ANG_W-1]}}, start_pose_reg[j]};
    assign blended = prod[33] ? (a_ext - r) : (a_ext + r);

    assign tri_down = (18'd65536 - {1'b0, t}) << 1;

    always_comb
    begin
        if (!active)
        begin
            blend_weight = '0;
        end
        else if ((segment_reg == 4'd0) && (segment_reg + 4'd1 == seg_n))
        begin
            blend_weight = (t < FRAC_HALF) ? {t[15:0], 1'b0} : tri_down[FRAC_W-1:0];
        end
        else if (segment_reg == 4'd0)
        begin
            blend_weight = t;
        end
        else if (segment_reg + 4'd1 == seg_n)
        begin
            blend_weight = FRAC_ONE - t;
        end
        else
        begin
            blend_weight = FRAC_ONE;
        end
    end

    assign leg           = cmd.idx[1:0];
    assign pbase         = {2'b00, leg} + {1'b0, leg, 1'b0};
    assign roll_ang      = pose_reg[pbase];
    assign pitch_ang     = pose_reg[pbase + 4'd1];
    assign knee          = pose_reg[pbase + 4'd2];
    assign playing       = running_reg;
    assign current_trick = trick_reg;
    assign accepted      = accepted_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            running_reg    <= 1'b0;
            trick_reg      <= TRICK_NONE;
            segment_reg    <= '0;
            elapsed_reg    <= '0;
            start_pose_reg <= STAND_POSE;
            accepted_reg   <= 1'b0;
        end
        else if (cmd.load)
        begin
            accepted_reg <= (in_command == CMD_START) && (in_trick <= TRICK_SHAKE);
            unique case (in_command)
                CMD_TICK:
                begin
                    if (running_reg)
                    begin
                        elapsed_reg <= elapsed_reg + dt_pos;
                    end
                end
                CMD_START:
                begin
                    if (in_trick <= TRICK_SHAKE)
                    begin
                        running_reg    <= 1'b1;
                        trick_reg      <= in_trick;
                        segment_reg    <= '0;
                        elapsed_reg    <= '0;
                        start_pose_reg <= STAND_POSE;
                    end
                end
                CMD_CANCEL:
                begin
                    running_reg    <= 1'b0;
                    trick_reg      <= TRICK_NONE;
                    segment_reg    <= '0;
                    elapsed_reg    <= '0;
                    start_pose_reg <= STAND_POSE;
                end
                default:
                begin
                end
            endcase
        end
        else if (cmd.advance)
        begin
            // finished segment: snap to its target, drop to standing after the last
            if (segment_reg + 4'd1 >= seg_n)
            begin
                running_reg    <= 1'b0;
                trick_reg      <= TRICK_NONE;
                segment_reg    <= '0;
                elapsed_reg    <= '0;
                start_pose_reg <= STAND_POSE;
            end
            else
            begin
                start_pose_reg <= frame.ang;
                elapsed_reg    <= elapsed_reg - {1'b0, dur};
                segment_reg    <= segment_reg + 4'd1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.div_init)
        begin
            rem_reg <= '0;
            quo_reg <= '0;
        end
        else if (cmd.div_step)
        begin
            rem_reg          <= ge ? DUR_W'(trial - {1'b0, dur}) : trial[DUR_W-1:0];
            quo_reg[cmd.idx] <= ge;
        end
        if (cmd.mul_step)
        begin
            pose_reg[j] <= blended[ANG_W-1:0];
        end
    end

endmodule

@@ hw/rtl/keyframe_pose_player.sv @@
// Keyframe pose player: plays built-in keyframe motions and blends joint poses.
// Top level; instantiates kpp_ctrl and kpp_datapath, uses kpp_pkg and the defines header.
//
// One item is taken at a time. The command is applied first, then each finished
// segment is advanced (at most MAX_SEGMENTS), the divider is started, the
// bit-serial divider works out the 37-bit quotient for the blend fraction, and
// the shared blend multiplier blends the 12 joints one after another; then come
// four result transfers, one per leg, each of which the output side can stall.
// The input port is ready only while no item is in flight.
`timescale 1ns / 1ps
`include "keyframe_pose_player_defines.svh"
module keyframe_pose_player #(
    parameter int KEYFRAME_ROM_DEPTH = kpp_pkg::KEYFRAME_ROM_DEPTH_DEF,
    parameter int MAX_SEGMENTS       = kpp_pkg::MAX_SEGMENTS_DEF
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [23:0] s_axis_tdata,  // trick[2:0], dt[23:3]
    input  logic [1:0]  s_axis_tuser,  // command[1:0]
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [71:0] m_axis_tdata,  // leg, roll_ang, pitch_ang, knee, blend_weight,
                                       // playing, current_trick, accepted, zero fill
    output logic        m_axis_tlast   // last_leg
);
    import kpp_pkg::*;

    kpp_cmd_t          cmd;
    kpp_status_t       status;
    logic [1:0]        leg;
    logic [ANG_W-1:0]  roll_ang;
    logic [ANG_W-1:0]  pitch_ang;
    logic [ANG_W-1:0]  knee;
    logic [FRAC_W-1:0] blend_weight;
    logic              playing;
    logic [2:0]        current_trick;
    logic              accepted;

    kpp_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (s_axis_tvalid),
        .in_ready  (s_axis_tready),
        .out_valid (m_axis_tvalid),
        .out_ready (m_axis_tready),
        .out_last  (m_axis_tlast),
        .status    (status),
        .cmd       (cmd)
    );

    kpp_datapath #(
        .KEYFRAME_ROM_DEPTH (KEYFRAME_ROM_DEPTH),
        .MAX_SEGMENTS       (MAX_SEGMENTS)
    ) u_datapath (
        .clk           (clk),
        .rst_n         (rst_n),
        .cmd           (cmd),
        .status        (status),
        .in_command    (s_axis_tuser),
        .in_trick      (s_axis_tdata[2:0]),
        .in_dt         (s_axis_tdata[23:3]),
        .leg           (leg),
        .roll_ang      (roll_ang),
        .pitch_ang     (pitch_ang),
        .knee          (knee),
        .blend_weight  (blend_weight),
        .playing       (playing),
        .current_trick (current_trick),
        .accepted      (accepted)
    );

    assign m_axis_tdata = {3'b000, accepted, current_trick, playing, blend_weight,
                           knee, pitch_ang, roll_ang, leg};

    `KPP_ASSERT_NEVER(a_no_overlap, s_axis_tready && m_axis_tvalid)
    `KPP_ASSERT_NEXT(a_ready_after_last, m_axis_tvalid && m_axis_tready && m_axis_tlast, s_axis_tready)
    `KPP_ASSERT_NEVER(a_accept_plays, m_axis_tvalid && m_axis_tdata[68] && !m_axis_tdata[64])

endmodule

@@ bench/tb_keyframe_pose_player.sv @@
// Self-checking bench for keyframe_pose_player: directed and random commands,
// with bursty input and a stalling result side, checked against a built-in predictor.
// Depends on kpp_pkg and the keyframe_pose_player RTL.
`timescale 1ns / 1ps
module tb_keyframe_pose_player;
    import kpp_pkg::*;

    localparam logic [1:0] CMD_RESERVED   = 2'd3;
    localparam logic [2:0] TRICK_SPARE_LO = 3'd5;
    localparam logic [2:0] TRICK_SPARE_HI = 3'd7;
    localparam int         STALL_LIMIT    = 6000;
    localparam int         LONG_HOLD      = 400;

    typedef enum int {
        P_STAND, P_WUP, P_WLEFT, P_WRIGHT, P_BFRONT, P_BREAR,
        P_GFRONT, P_GREAR, P_SPOS, P_SNEG
    } leg_pose_t;

    localparam int LEG_ANG [30] = '{
        0, 3129, -6742,     492, 1311, -9011,   -819, 1147, -9011,
        1843, 1556, -9011,  0, 4588, -8602,     0, 3195, -6554,
        737, 5939, -8397,   0, 5530, -10445,    901, 3129, -6742,
        -655, 3129, -6742
    };

    localparam int KF_LEGS [88] = '{
        P_WUP, P_STAND, P_STAND, P_STAND,      P_WLEFT, P_STAND, P_STAND, P_STAND,
        P_WRIGHT, P_STAND, P_STAND, P_STAND,   P_WLEFT, P_STAND, P_STAND, P_STAND,
        P_WRIGHT, P_STAND, P_STAND, P_STAND,   P_WUP, P_STAND, P_STAND, P_STAND,
        P_STAND, P_STAND, P_STAND, P_STAND,    P_BFRONT, P_BFRONT, P_BREAR, P_BREAR,
        P_BFRONT, P_BFRONT, P_BREAR, P_BREAR,  P_STAND, P_STAND, P_STAND, P_STAND,
        P_GFRONT, P_GFRONT, P_GREAR, P_GREAR,  P_GFRONT, P_GFRONT, P_GREAR, P_GREAR,
        P_STAND, P_STAND, P_STAND, P_STAND,    P_SPOS, P_SNEG, P_SPOS, P_SNEG,
        P_SNEG, P_SPOS, P_SNEG, P_SPOS,        P_SPOS, P_SNEG, P_SPOS, P_SNEG,
        P_SNEG, P_SPOS, P_SNEG, P_SPOS,        P_SPOS, P_SNEG, P_SPOS, P_SNEG,
        P_SNEG, P_SPOS, P_SNEG, P_SPOS,        P_SPOS, P_SNEG, P_SPOS, P_SNEG,
        P_SNEG, P_SPOS, P_SNEG, P_SPOS,        P_STAND, P_STAND, P_STAND, P_STAND
    };

    localparam int KF_DUR [22] = '{
        450000, 220000, 220000, 220000, 220000, 200000, 450000, 600000, 700000,
        600000, 650000, 900000, 650000, 180000, 140000, 140000, 140000, 140000,
        140000, 140000, 140000, 350000
    };

    localparam int TRICK_FIRST [4]  = '{0, 7, 10, 13};
    localparam int TRICK_FRAMES [4] = '{7, 3, 3, 9};

    typedef struct {
        logic [1:0]        leg;
        logic [ANG_W-1:0]  roll;
        logic [ANG_W-1:0]  pitch;
        logic [ANG_W-1:0]  knee;
        logic [FRAC_W-1:0] weight;
        logic              playing;
        logic [2:0]        trick;
        logic              accepted;
        logic              last;
    } leg_result_t;

    class pose_scoreboard;
        bit           running;
        logic [2:0]   trick_id;
        int           segment;
        longint       elapsed_us;
        int           start_pose [12];
        leg_result_t  pending_legs [$];
        int           errors;
        int           items;
        int           results;
        int           starts [4];

        function new();
            errors = 0;
            items = 0;
            results = 0;
            foreach (starts[i]) starts[i] = 0;
            stand_still();
        endfunction

        function void stand_still();
            running = 0;
            trick_id = TRICK_NONE;
            segment = 0;
            elapsed_us = 0;
            for (int j = 0; j < 12; j++) start_pose[j] = LEG_ANG[j % 3];
        endfunction

        function int segments_in_trick();
            int n;
            if (trick_id > TRICK_SHAKE) return 0;
            n = TRICK_FRAMES[trick_id];
            return n < MAX_SEGMENTS_DEF ? n : MAX_SEGMENTS_DEF;
        endfunction

        function int keyframe_index();
            if (trick_id > TRICK_SHAKE) return -1;
            return TRICK_FIRST[trick_id] + segment;
        endfunction

        function longint keyframe_dur(int idx);
            if (idx < 0 || idx >= 22 || KF_DUR[idx] == 0) return 1;
            return KF_DUR[idx];
        endfunction

        function int keyframe_angle(int idx, int j);
            if (idx < 0 || idx >= 22) return 0;
            return LEG_ANG[KF_LEGS[idx * 4 + j / 3] * 3 + j % 3];
        endfunction

        function int mix_angle(int a, int b, longint t);
            longint p;
            longint m;
            int r;
            p = t * longint'(b - a);
            m = p < 0 ? -p : p;
            r = int'((m + 32768) >>> 16);
            return p < 0 ? a - r : a + r;
        endfunction

        function void note_command(logic [1:0] cmd, logic [2:0] trk, logic [DT_W-1:0] dt_raw);
            bit took;
            int pose [12];
            longint weight;
            longint t;
            int idx;
            int n;
            leg_result_t r;
            took = 0;
            weight = 0;
            items++;
            if (cmd == CMD_TICK)
            begin
                if (running)
                begin
                    elapsed_us += dt_raw[DT_W-1] ? 0 : longint'(dt_raw);
                    for (int g = 0; g < 16 && running && segment < segments_in_trick(); g++)
                    begin
                        idx = keyframe_index();
                        if (elapsed_us < keyframe_dur(idx)) break;
                        for (int j = 0; j < 12; j++) start_pose[j] = keyframe_angle(idx, j);
                        elapsed_us -= keyframe_dur(idx);
                        segment++;
                        if (segment >= segments_in_trick()) stand_still();
                    end
                end
            end
            else if (cmd == CMD_START)
            begin
                if (trk <= TRICK_SHAKE)
                begin
                    stand_still();
                    running = 1;
                    trick_id = trk;
                    took = 1;
                    starts[trk]++;
                end
            end
            else if (cmd == CMD_CANCEL)
            begin
                stand_still();
            end
            n = segments_in_trick();
            if (!running || segment >= n)
            begin
                for (int j = 0; j < 12; j++) pose[j] = LEG_ANG[j % 3];
            end
            else
            begin
                idx = keyframe_index();
                t = (elapsed_us << 16) / keyframe_dur(idx);
                if (t > 65536) t = 65536;
                for (int j = 0; j < 12; j++)
                    pose[j] = mix_angle(start_pose[j], keyframe_angle(idx, j), t);
                if (segment == 0 && segment + 1 == n)
                    weight = t < 32768 ? 2 * t : 2 * (65536 - t);
                else if (segment == 0)
                    weight = t;
                else if (segment + 1 == n)
                    weight = 65536 - t;
                else
                    weight = 65536;
            end
            for (int leg = 0; leg < 4; leg++)
            begin
                r.leg = leg[1:0];
                r.roll = ANG_W'(pose[leg * 3]);
                r.pitch = ANG_W'(pose[leg * 3 + 1]);
                r.knee = ANG_W'(pose[leg * 3 + 2]);
                r.weight = FRAC_W'(weight);
                r.playing = running;
                r.trick = trick_id;
                r.accepted = took;
                r.last = (leg == 3);
                pending_legs.push_back(r);
            end
        endfunction

        function void check_leg(logic [71:0] data, logic last);
            leg_result_t e;
            leg_result_t a;
            a.leg = data[1:0];
            a.roll = data[16:2];
            a.pitch = data[31:17];
            a.knee = data[46:32];
            a.weight = data[63:47];
            a.playing = data[64];
            a.trick = data[67:65];
            a.accepted = data[68];
            a.last = last;
            results++;
            if (pending_legs.size() == 0)
            begin
                errors++;
                $display("%0t: unexpected result transfer data=%h last=%b", $time, data, last);
                return;
            end
            e = pending_legs.pop_front();
            if (a.leg != e.leg) report("leg", e.leg, a.leg);
            if (a.roll != e.roll) report("roll_ang", e.roll, a.roll);
            if (a.pitch != e.pitch) report("pitch_ang", e.pitch, a.pitch);
            if (a.knee != e.knee) report("knee", e.knee, a.knee);
            if (a.weight != e.weight) report("blend_weight", e.weight, a.weight);
            if (a.playing != e.playing) report("playing", e.playing, a.playing);
            if (a.trick != e.trick) report("current_trick", e.trick, a.trick);
            if (a.accepted != e.accepted) report("accepted", e.accepted, a.accepted);
            if (a.last != e.last) report("last_leg", e.last, a.last);
        endfunction

        function void report(string field, longint exp_v, longint act_v);
            errors++;
            $display("%0t: %s mismatch, expected %0d, got %0d", $time, field, exp_v, act_v);
        endfunction
    endclass

    logic        clk;
    logic        rst_n;
    logic        s_axis_tvalid;
    logic        s_axis_tready;
    logic [23:0] s_axis_tdata;
    logic [1:0]  s_axis_tuser;
    logic        m_axis_tvalid;
    logic        m_axis_tready;
    logic [71:0] m_axis_tdata;
    logic        m_axis_tlast;

    pose_scoreboard sb;
    int  burst_left;
    int  hold_requests;
    int  idle_cycles;

    keyframe_pose_player dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tlast  (m_axis_tlast)
    );

    always
    begin
        clk = 1'b0;
        #4;
        clk = 1'b1;
        #4;
    end

    task automatic send_cmd(logic [1:0] cmd, logic [2:0] trk, logic [DT_W-1:0] dt_raw);
        int gap;
        if (burst_left == 0)
        begin
            gap = ($urandom_range(0, 3) == 0) ? 0 : int'($urandom_range(1, 12));
            if (gap > 0)
            begin
                s_axis_tvalid <= 1'b0;
                repeat (gap) @(posedge clk);
            end
            burst_left = int'($urandom_range(1, 10));
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata <= {dt_raw, trk};
        s_axis_tuser <= cmd;
        @(posedge clk);
        while (!s_axis_tready) @(posedge clk);
        sb.note_command(cmd, trk, dt_raw);
        burst_left--;
    endtask

    task automatic tick(int dt);
        send_cmd(CMD_TICK, 3'($urandom), DT_W'(dt));
    endtask

    task automatic wait_drained();
        s_axis_tvalid <= 1'b0;
        @(posedge clk);
        while (sb.pending_legs.size() != 0) @(posedge clk);
    endtask

    function automatic int pick_dt();
        int sel;
        sel = int'($urandom_range(0, 19));
        if (sel < 12) return int'($urandom_range(0, 250000));
        if (sel < 14) return -int'($urandom_range(0, 300000));
        if (sel < 17) return int'($urandom_range(0, 2000000)) - 1000000;
        if (sel < 19) return int'($urandom_range(0, 2000));
        return 0;
    endfunction

    initial
    begin
        s_axis_tvalid <= 1'b0;
        s_axis_tdata <= '0;
        s_axis_tuser <= CMD_TICK;
        m_axis_tready <= 1'b0;
        rst_n <= 1'b0;
    end

    initial
    begin
        int hold_left;
        int stall_phase;
        int holds_done;
        hold_left = 0;
        stall_phase = 0;
        holds_done = 0;
        forever
        begin
            @(posedge clk);
            if (m_axis_tvalid && m_axis_tready) sb.check_leg(m_axis_tdata, m_axis_tlast);
            if (hold_requests != holds_done)
            begin
                holds_done = hold_requests;
                hold_left = LONG_HOLD;
            end
            if (stall_phase == 0) stall_phase = int'($urandom_range(1, 60));
            stall_phase--;
            if (hold_left > 0)
            begin
                hold_left--;
                m_axis_tready <= 1'b0;
            end
            else if (stall_phase > 30)
            begin
                m_axis_tready <= 1'b1;
            end
            else
            begin
                m_axis_tready <= ($urandom_range(0, 2) != 0);
            end
        end
    end

    always @(posedge clk)
    begin
        if (!rst_n || (s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles > STALL_LIMIT)
        begin
            $display("watchdog expired at %0t", $time);
            $display("keyframe_pose_player regression: fail");
            $finish;
        end
    end

    initial
    begin
        int sel;
        sb = new();
        burst_left = 0;
        hold_requests = 0;
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        tick(100000);
        send_cmd(CMD_RESERVED, TRICK_WAVE, '0);
        send_cmd(CMD_START, TRICK_NONE, '0);
        send_cmd(CMD_START, TRICK_SPARE_LO, '0);
        send_cmd(CMD_START, TRICK_SPARE_HI, DT_W'(-1));
        send_cmd(CMD_START, TRICK_WAVE, '0);
        tick(-1000000);
        tick(1000000);
        tick(0);
        send_cmd(CMD_START, TRICK_BOW, '0);
        tick(300000);
        send_cmd(CMD_RESERVED, TRICK_NONE, DT_W'(1000000));
        send_cmd(CMD_START, TRICK_BEG, '0);
        send_cmd(CMD_CANCEL, TRICK_BEG, '0);
        tick(500000);
        send_cmd(CMD_START, TRICK_SHAKE, '0);
        tick(90000);
        tick(1000000);
        tick(1000000);
        send_cmd(CMD_START, TRICK_BEG, '0);
        tick(650000);
        tick(1000000);
        send_cmd(CMD_START, TRICK_WAVE, '0);
        send_cmd(CMD_START, TRICK_SHAKE, '0);
        tick(-1);

        for (int i = 0; i < 500; i++)
        begin
            if (i == 150)
            begin
                hold_requests++;
                burst_left = 40;
            end
            if (i == 300 || i == 420) wait_drained();
            sel = int'($urandom_range(0, 99));
            if (sel < 14)
                send_cmd(CMD_START, 3'($urandom_range(0, 3)), DT_W'($urandom));
            else if (sel < 16)
                send_cmd(CMD_START, 3'($urandom_range(4, 7)), DT_W'($urandom));
            else if (sel < 20)
                send_cmd(CMD_CANCEL, 3'($urandom), DT_W'($urandom));
            else if (sel < 22)
                send_cmd(CMD_RESERVED, 3'($urandom), DT_W'($urandom));
            else
                tick(pick_dt());
        end

        wait_drained();
        repeat (80) @(posedge clk);
        $display("%0d commands, %0d leg results; starts wave/bow/beg/shake = %0d/%0d/%0d/%0d",
                 sb.items, sb.results, sb.starts[0], sb.starts[1], sb.starts[2], sb.starts[3]);
        $display("covered idle, rejected starts, reserved command, cancel, negative dt, overrun");
        if (sb.errors == 0 && sb.pending_legs.size() == 0)
        begin
            $display("keyframe_pose_player regression: pass");
        end
        else
        begin
            $display("%0d errors, %0d results outstanding", sb.errors, sb.pending_legs.size());
            $display("keyframe_pose_player regression: fail");
        end
        $finish;
    end
endmodule

@@ sim.f @@
+incdir+hw/rtl
hw/rtl/kpp_pkg.sv
hw/rtl/kpp_ctrl.sv
hw/rtl/kpp_datapath.sv
hw/rtl/keyframe_pose_player.sv
bench/tb_keyframe_pose_player.sv
